[rtl/tqbl_pkg.sv]
// tqbl_pkg: shared constants and types for the two-queue burst-limited priority block
// no dependencies; imported by two_queue_burst_limited_priority
package tqbl_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int TAG_WIDTH   = 16;
  localparam int PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int LIMIT_W     = 4;
  localparam int FUNC_W      = 2;
  localparam int STATUS_W    = 3;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(3);

  typedef enum logic [FUNC_W-1:0] {
    FUNC_ENQ_NORMAL = 2'd0,
    FUNC_ENQ_PRIO   = 2'd1,
    FUNC_SERVE      = 2'd2,
    FUNC_SERVE_ALT  = 2'd3
  } func_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_ENQUEUED        = 3'd0,
    ST_SERVED_NORMAL   = 3'd1,
    ST_SERVED_PRIORITY = 3'd2,
    ST_WAIT            = 3'd3,
    ST_DROPPED         = 3'd4
  } status_t;

endpackage

[rtl/two_queue_burst_limited_priority.sv]
// two_queue_burst_limited_priority: two tag rings in synchronous memories with a
// burst-limited priority arbiter; depends on tqbl_pkg
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+---------------------------
//   in      | input     | in_valid / in_stall  | in_func, in_item_tag
//   out     | output    | out_valid / out_stall| out_status, out_served_tag
//   cfg     | input     | cfg_valid / cfg_ready| cfg_data (burst limit)
//
// enqueue and wait transactions: the result is registered at accept
// a served transaction waits in S_READ for the registered read of the ring memory
// one transaction is in flight at a time; in_stall is high during the memory read
// in_stall is also high while a result waits and out_stall holds it
// synchronous active-low reset clears pointers, counts, burst count and limit (3)
// the ring memories need no reset: only entries that hold queued tags are read
module two_queue_burst_limited_priority (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [tqbl_pkg::FUNC_W-1:0]      in_func,
  input  logic [tqbl_pkg::TAG_WIDTH-1:0]   in_item_tag,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [tqbl_pkg::STATUS_W-1:0]    out_status,
  output logic [tqbl_pkg::TAG_WIDTH-1:0]   out_served_tag,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [tqbl_pkg::LIMIT_W-1:0]     cfg_data
);
  import tqbl_pkg::*;

  typedef enum logic {S_IDLE, S_READ} state_t;

  // ring storage
  logic [TAG_WIDTH-1:0] nrm_mem [QUEUE_DEPTH];
  logic [TAG_WIDTH-1:0] pri_mem [QUEUE_DEPTH];
  logic [TAG_WIDTH-1:0] nrm_rd_r, pri_rd_r;

  // control state
  state_t               state_r, state_nxt;
  logic [PTR_W-1:0]     nrm_head_r, nrm_head_nxt, pri_head_r, pri_head_nxt;
  logic [CNT_W-1:0]     nrm_cnt_r, nrm_cnt_nxt, pri_cnt_r, pri_cnt_nxt;
  logic [LIMIT_W-1:0]   burst_r, burst_nxt;
  logic [LIMIT_W-1:0]   limit_r, limit_nxt;
  logic                 sel_pri_r, sel_pri_nxt;

  // output register
  logic                 out_valid_r, out_valid_nxt;
  status_t              out_status_r, out_status_nxt;
  logic [TAG_WIDTH-1:0] out_tag_r, out_tag_nxt;

  logic                 in_acc, is_serve;
  logic                 nrm_full, pri_full, nrm_empty, pri_empty;
  logic                 serve_pri;
  logic                 wr_nrm, wr_pri, rd_nrm, rd_pri;
  logic [PTR_W-1:0]     nrm_tail, pri_tail;
  logic [CNT_W:0]       nrm_sum, pri_sum;
  logic [LIMIT_W:0]     burst_inc;

  // one transaction at a time; hold off while the memory read is pending
  // or while the output register is occupied and not being drained
  assign in_stall  = (state_r != S_IDLE) || (out_valid_r && out_stall);
  assign in_acc    = in_valid && !in_stall;
  assign is_serve  = in_func[FUNC_W-1];   // both upper codes decode as serve
  assign cfg_ready = 1'b1;

  assign nrm_full  = (nrm_cnt_r == CNT_W'(QUEUE_DEPTH));
  assign pri_full  = (pri_cnt_r == CNT_W'(QUEUE_DEPTH));
  assign nrm_empty = (nrm_cnt_r == '0);
  assign pri_empty = (pri_cnt_r == '0);

  // tail = head + count, wrapped into the ring
  assign nrm_sum  = (CNT_W + 1)'(nrm_head_r) + (CNT_W + 1)'(nrm_cnt_r);
  assign pri_sum  = (CNT_W + 1)'(pri_head_r) + (CNT_W + 1)'(pri_cnt_r);
  assign nrm_tail = (nrm_sum >= (CNT_W + 1)'(QUEUE_DEPTH))
                  ? PTR_W'(nrm_sum - (CNT_W + 1)'(QUEUE_DEPTH)) : PTR_W'(nrm_sum);
  assign pri_tail = (pri_sum >= (CNT_W + 1)'(QUEUE_DEPTH))
                  ? PTR_W'(pri_sum - (CNT_W + 1)'(QUEUE_DEPTH)) : PTR_W'(pri_sum);

  // priority wins while under the burst limit; otherwise normal, if any is waiting
  assign serve_pri = (!pri_empty && (burst_r < limit_r)) || (nrm_empty && !pri_empty);
  assign burst_inc = (LIMIT_W + 1)'(burst_r) + (LIMIT_W + 1)'(1);

  assign wr_nrm = in_acc && !is_serve && (in_func == FUNC_ENQ_NORMAL) && !nrm_full;
  assign wr_pri = in_acc && !is_serve && (in_func == FUNC_ENQ_PRIO) && !pri_full;
  assign rd_pri = in_acc && is_serve && serve_pri;
  assign rd_nrm = in_acc && is_serve && !serve_pri && !nrm_empty;

  always_comb begin
    state_nxt      = state_r;
    nrm_head_nxt   = nrm_head_r;
    pri_head_nxt   = pri_head_r;
    nrm_cnt_nxt    = nrm_cnt_r;
    pri_cnt_nxt    = pri_cnt_r;
    burst_nxt      = burst_r;
    limit_nxt      = limit_r;
    sel_pri_nxt    = sel_pri_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_status_nxt = out_status_r;
    out_tag_nxt    = out_tag_r;

    if (cfg_valid && cfg_ready) begin
      limit_nxt = cfg_data;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (!is_serve) begin
            // enqueue: result is known at once
            out_valid_nxt  = 1'b1;
            out_tag_nxt    = '0;
            out_status_nxt = (wr_nrm || wr_pri) ? ST_ENQUEUED : ST_DROPPED;
            if (wr_nrm) nrm_cnt_nxt = nrm_cnt_r + CNT_W'(1);
            if (wr_pri) pri_cnt_nxt = pri_cnt_r + CNT_W'(1);
          end else if (rd_pri) begin
            sel_pri_nxt  = 1'b1;
            state_nxt    = S_READ;
            pri_cnt_nxt  = pri_cnt_r - CNT_W'(1);
            pri_head_nxt = (pri_head_r == PTR_W'(QUEUE_DEPTH - 1))
                         ? '0 : pri_head_r + PTR_W'(1);
            // saturate at the limit
            burst_nxt    = (burst_inc < (LIMIT_W + 1)'(limit_r))
                         ? LIMIT_W'(burst_inc) : limit_r;
          end else if (rd_nrm) begin
            sel_pri_nxt  = 1'b0;
            state_nxt    = S_READ;
            nrm_cnt_nxt  = nrm_cnt_r - CNT_W'(1);
            nrm_head_nxt = (nrm_head_r == PTR_W'(QUEUE_DEPTH - 1))
                         ? '0 : nrm_head_r + PTR_W'(1);
            burst_nxt    = '0;
          end else begin
            // both rings empty
            out_valid_nxt  = 1'b1;
            out_tag_nxt    = '0;
            out_status_nxt = ST_WAIT;
          end
        end
      end
      S_READ: begin
        // memory data arrived; output register is free here by the stall rule
        state_nxt      = S_IDLE;
        out_valid_nxt  = 1'b1;
        out_status_nxt = sel_pri_r ? ST_SERVED_PRIORITY : ST_SERVED_NORMAL;
        out_tag_nxt    = sel_pri_r ? pri_rd_r : nrm_rd_r;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      nrm_head_r  <= '0;
      pri_head_r  <= '0;
      nrm_cnt_r   <= '0;
      pri_cnt_r   <= '0;
      burst_r     <= '0;
      limit_r     <= LIMIT_RESET;
      sel_pri_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      nrm_head_r  <= nrm_head_nxt;
      pri_head_r  <= pri_head_nxt;
      nrm_cnt_r   <= nrm_cnt_nxt;
      pri_cnt_r   <= pri_cnt_nxt;
      burst_r     <= burst_nxt;
      limit_r     <= limit_nxt;
      sel_pri_r   <= sel_pri_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_status_r <= out_status_nxt;
    out_tag_r    <= out_tag_nxt;
  end

  // normal ring memory
  always_ff @(posedge clk) begin
    if (wr_nrm) nrm_mem[nrm_tail] <= in_item_tag;
    if (rd_nrm) nrm_rd_r <= nrm_mem[nrm_head_r];
  end

  // priority ring memory
  always_ff @(posedge clk) begin
    if (wr_pri) pri_mem[pri_tail] <= in_item_tag;
    if (rd_pri) pri_rd_r <= pri_mem[pri_head_r];
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_served_tag = out_tag_r;

  // a pending memory read blocks new transactions
  a_read_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_READ) |-> in_stall)
    else $error("transaction accepted during ring read");

  // the read state always delivers a result in the next cycle
  a_read_delivers: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_READ) |=> (out_valid && ((out_status == ST_SERVED_NORMAL) ||
                                           (out_status == ST_SERVED_PRIORITY))))
    else $error("served result missing after ring read");

  // ring fill never passes the depth
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (nrm_cnt_r <= CNT_W'(QUEUE_DEPTH)) && (pri_cnt_r <= CNT_W'(QUEUE_DEPTH)))
    else $error("ring count beyond depth");

  // non-serve results carry a zero tag
  a_zero_tag: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && ((out_status == ST_ENQUEUED) || (out_status == ST_WAIT) ||
                   (out_status == ST_DROPPED))) |-> (out_served_tag == '0))
    else $error("nonzero tag on non-serve result");

endmodule
